// ===== rtl/pixel_percent_fade_16bit_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for pixel_percent_fade_16bit_top
// Shorthands for clocked concurrent checks, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef PIXEL_PERCENT_FADE_16BIT_TOP_ASSERT_SVH
`define PIXEL_PERCENT_FADE_16BIT_TOP_ASSERT_SVH

// check outside of reset
`define PXF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define PXF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pxf_pkg.sv =====
// ----------------------------------------------------------------------------
// pxf_pkg
// Types, register map and constants of the percent fade pixel block.
// ----------------------------------------------------------------------------
package pxf_pkg;

  // register word index (byte address / 4)
  localparam logic [2:0] REG_RED_PCT   = 3'd0;
  localparam logic [2:0] REG_GREEN_PCT = 3'd1;
  localparam logic [2:0] REG_BLUE_PCT  = 3'd2;
  localparam logic [2:0] REG_RED_POS   = 3'd3;
  localparam logic [2:0] REG_GREEN_POS = 3'd4;
  localparam logic [2:0] REG_BLUE_POS  = 3'd5;
  localparam logic [2:0] REG_LOSSES    = 3'd6;

  localparam logic [7:0] PCT_RESET    = 8'd100;
  localparam logic [3:0] RED_POS_RST  = 4'd11;
  localparam logic [3:0] GRN_POS_RST  = 4'd5;
  localparam logic [3:0] BLU_POS_RST  = 4'd0;
  localparam logic [8:0] LOSSES_RESET = 9'd211;

  localparam logic [7:0] PCT_UNITY = 8'd100;
  localparam logic [7:0] PCT_MAX   = 8'd200;

  // floor(n / 100) = (n * 5243) >> 19, exact for n < 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef struct packed {
    logic [7:0] pct;
    logic [3:0] pos;
    logic [2:0] loss;
  } chan_cfg_t;

endpackage

// ===== rtl/pixel_percent_fade_16bit_top.sv =====
// ----------------------------------------------------------------------------
// pixel_percent_fade_16bit_top
// Per-channel percent fade of a 16-bit packed RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one faded word per clock
// unless stalled; each word passes the input register, the fade product
// register and the output register in turn, with the 8x8 fade product and the
// divide-by-100 reciprocal multiply each in a stage of their own. Stalls
// back up through the stages without losing a slot. Channel percents (0
// black, 100 unchanged, 200 white, larger saturates), field positions and
// bit losses are set over the APB port, at byte addresses 0x00..0x18, and
// must only be changed while the pipe is empty.
`include "pixel_percent_fade_16bit_top_assert.svh"

module pixel_percent_fade_16bit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel
);

  logic [7:0] red_percent;
  logic [7:0] green_percent;
  logic [7:0] blue_percent;
  logic [3:0] red_position;
  logic [3:0] green_position;
  logic [3:0] blue_position;
  logic [8:0] channel_losses;

  logic       wr_en;
  logic [2:0] reg_idx;

  pxf_pkg::chan_cfg_t red_cfg;
  pxf_pkg::chan_cfg_t green_cfg;
  pxf_pkg::chan_cfg_t blue_cfg;

  logic        a_valid;
  logic [15:0] a_pixel;
  logic        b_valid;
  logic        a_free;
  logic        b_free;
  logic        c_move;
  logic        load_b;
  logic        load_c;

  logic [15:0] red_val;
  logic [15:0] green_val;
  logic [15:0] blue_val;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      red_percent    <= pxf_pkg::PCT_RESET;
      green_percent  <= pxf_pkg::PCT_RESET;
      blue_percent   <= pxf_pkg::PCT_RESET;
      red_position   <= pxf_pkg::RED_POS_RST;
      green_position <= pxf_pkg::GRN_POS_RST;
      blue_position  <= pxf_pkg::BLU_POS_RST;
      channel_losses <= pxf_pkg::LOSSES_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        pxf_pkg::REG_RED_PCT:   red_percent    <= pwdata[7:0];
        pxf_pkg::REG_GREEN_PCT: green_percent  <= pwdata[7:0];
        pxf_pkg::REG_BLUE_PCT:  blue_percent   <= pwdata[7:0];
        pxf_pkg::REG_RED_POS:   red_position   <= pwdata[3:0];
        pxf_pkg::REG_GREEN_POS: green_position <= pwdata[3:0];
        pxf_pkg::REG_BLUE_POS:  blue_position  <= pwdata[3:0];
        pxf_pkg::REG_LOSSES:    channel_losses <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pxf_pkg::REG_RED_PCT:   prdata = {24'd0, red_percent};
      pxf_pkg::REG_GREEN_PCT: prdata = {24'd0, green_percent};
      pxf_pkg::REG_BLUE_PCT:  prdata = {24'd0, blue_percent};
      pxf_pkg::REG_RED_POS:   prdata = {28'd0, red_position};
      pxf_pkg::REG_GREEN_POS: prdata = {28'd0, green_position};
      pxf_pkg::REG_BLUE_POS:  prdata = {28'd0, blue_position};
      pxf_pkg::REG_LOSSES:    prdata = {23'd0, channel_losses};
      default:                prdata = 32'd0;
    endcase
  end

  assign red_cfg   = '{pct: red_percent,   pos: red_position,   loss: channel_losses[8:6]};
  assign green_cfg = '{pct: green_percent, pos: green_position, loss: channel_losses[5:3]};
  assign blue_cfg  = '{pct: blue_percent,  pos: blue_position,  loss: channel_losses[2:0]};

  // ---------------- pipe control ----------------
  assign c_move   = !out_valid || !out_stall;
  assign b_free   = !b_valid || c_move;
  assign a_free   = !a_valid || b_free;
  assign in_stall = !a_free;
  assign load_b   = a_valid && b_free;
  assign load_c   = b_valid && c_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_free) a_valid <= in_valid;
      if (b_free) b_valid <= a_valid;
      if (c_move) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      a_pixel <= in_pixel;
    end
  end

  // ---------------- channels ----------------
  pxf_chan u_red (
    .clk        (clk),
    .load       (load_b),
    .pixel      (a_pixel),
    .cfg        (red_cfg),
    .packed_val (red_val)
  );

  pxf_chan u_green (
    .clk        (clk),
    .load       (load_b),
    .pixel      (a_pixel),
    .cfg        (green_cfg),
    .packed_val (green_val)
  );

  pxf_chan u_blue (
    .clk        (clk),
    .load       (load_b),
    .pixel      (a_pixel),
    .cfg        (blue_cfg),
    .packed_val (blue_val)
  );

  always_ff @(posedge clk) begin
    if (load_c) begin
      out_pixel <= red_val | green_val | blue_val;
    end
  end

  // ---------------- checks ----------------
  `PXF_ASSERT(stall_only_full, in_stall |-> (a_valid && b_valid && out_valid), "input stalled with a free stage")
  `PXF_ASSERT(mid_word_kept, (b_valid && out_valid && out_stall) |=> b_valid, "word lost from product stage")
  `PXF_ASSERT_RST(reset_empties, rst |=> (!out_valid && !b_valid && !a_valid), "pipe not empty")

endmodule

// ===== rtl/pxf_chan.sv =====
// ----------------------------------------------------------------------------
// pxf_chan
// One color channel: unpack, fade product (registered), divide by 100 and
// repack. The repacked value is combinational off the product register.
// ----------------------------------------------------------------------------
module pxf_chan (
  input  logic              clk,
  input  logic              load,
  input  logic [15:0]       pixel,
  input  pxf_pkg::chan_cfg_t cfg,
  output logic [15:0]       packed_val
);

  logic [15:0] field16;
  logic [7:0]  mask;
  logic [7:0]  field;
  logic [7:0]  comp;
  logic [7:0]  c;
  logic [7:0]  p;
  logic        hi;
  logic [7:0]  mul_a;
  logic [7:0]  mul_b;
  logic [15:0] prod;

  logic [14:0] n;
  logic [7:0]  c_hold;
  logic        hi_hold;

  logic [27:0] recip;
  logic [7:0]  q;
  logic [7:0]  v;
  logic [7:0]  v_shr;

  // stage 1: component, saturated percent, one 8x8 product
  assign field16 = pixel >> cfg.pos;
  assign mask    = 8'hFF >> cfg.loss;
  assign field   = field16[7:0] & mask;
  assign comp    = field << cfg.loss;
  assign c       = {comp[7:3], 3'b111};
  assign p       = (cfg.pct > pxf_pkg::PCT_MAX) ? pxf_pkg::PCT_MAX : cfg.pct;
  assign hi      = p > pxf_pkg::PCT_UNITY;
  // above unity: fade toward white, (255-c) is ~c
  assign mul_a   = hi ? ~c : c;
  assign mul_b   = hi ? (p - pxf_pkg::PCT_UNITY) : p;
  assign prod    = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (load) begin
      n       <= prod[14:0];
      c_hold  <= c;
      hi_hold <= hi;
    end
  end

  // stage 2: divide by 100, add back, repack
  assign recip      = {13'd0, n} * {15'd0, pxf_pkg::DIV100_MUL};
  assign q          = recip[pxf_pkg::DIV100_SHIFT +: 8];
  assign v          = hi_hold ? (c_hold + q) : q;
  assign v_shr      = v >> cfg.loss;
  assign packed_val = {8'd0, v_shr} << cfg.pos;

endmodule
